// ===== rtl/pdh_pkg.sv =====
// pdh_pkg: shared types and codes of the pair distance histogram
package pdh_pkg;

    localparam int CW_MAX  = 32;   // widest coordinate carried between front and back
    localparam int CNT_W   = 24;
    localparam int SEL_W   = 6;
    localparam int OUTC_W  = 2;
    localparam int VAL_W   = 64;
    localparam int CFG_W   = 24;
    localparam int NBIN_W  = 7;
    localparam int DIST_W  = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_PAIR = 2'd0;
    localparam logic [1:0] OP_HOLD = 2'd1;
    localparam logic [1:0] OP_TEST = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [OUTC_W-1:0] OUT_PRUNED = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_BULK   = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_SPLIT  = 2'd2;

    localparam logic [2:0] REG_BIN_MIN   = 3'd0;
    localparam logic [2:0] REG_BIN_MAX   = 3'd1;
    localparam logic [2:0] REG_BIN_STEP  = 3'd2;
    localparam logic [2:0] REG_BINS_USED = 3'd3;
    localparam logic [2:0] REG_STRICT    = 3'd4;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [CW_MAX-1:0] a_x;
        logic signed [CW_MAX-1:0] a_y;
        logic signed [CW_MAX-1:0] a_z;
        logic signed [CW_MAX-1:0] b_x;
        logic signed [CW_MAX-1:0] b_y;
        logic signed [CW_MAX-1:0] b_z;
        logic [CNT_W-1:0]         point_count;
        logic                     same_node;
        logic [SEL_W-1:0]         bin_select;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0]  bin_min;
        logic [CFG_W-1:0]  bin_max;
        logic [CFG_W-1:0]  bin_step;
        logic [NBIN_W-1:0] bins_in_use;
        logic              strict_low_edge;
    } cfg_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [SEL_W-1:0]  bulk_bin;
        logic [VAL_W-1:0]  bin_value;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic res_valid;
    } back_stat_t;

endpackage

// ===== rtl/pdh_front.sv =====
// pdh_front: two-entry input queue that takes transactions and hands them to the back end
module pdh_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            hold,
    input  pdh_pkg::item_t  item_in,
    output logic            full,
    output logic            item_valid,
    output pdh_pkg::item_t  item_out,
    input  logic            take
);

    pdh_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push;
    logic           do_take;

    assign full       = (cnt_reg == 2'd2) || hold;
    assign item_valid = (cnt_reg != 2'd0);
    assign item_out   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = take && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_take)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_take)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!do_push && do_take)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ===== rtl/pdh_back.sv =====
// pdh_back: sequencer that measures distances, bins them and updates the histogram memory
module pdh_back
#(
    parameter int NUM_BINS   = 64,
    parameter int COORD_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdh_pkg::cfg_t        cfg,
    input  logic                 item_valid,
    input  pdh_pkg::item_t       item,
    output logic                 take,
    input  logic                 pop,
    output pdh_pkg::back_stat_t  stat,
    output pdh_pkg::result_t     res
);

    localparam int GW     = COORD_BITS + 1;
    localparam int SQ_W   = 2 * GW;
    localparam int ACC_W  = ((SQ_W > 64) ? SQ_W : 64) + 1;
    localparam int IW     = $clog2(NUM_BINS);
    localparam int NB_W   = $clog2(NUM_BINS + 1);
    localparam int NC_W   = (NB_W > pdh_pkg::NBIN_W) ? NB_W : pdh_pkg::NBIN_W;
    localparam int NW_W   = NC_W + pdh_pkg::CFG_W;
    localparam int CMP_W  = ((NW_W > pdh_pkg::DIST_W) ? NW_W : pdh_pkg::DIST_W) + 1;
    localparam int DV_W   = ((pdh_pkg::CFG_W + IW > pdh_pkg::DIST_W) ?
                             pdh_pkg::CFG_W + IW : pdh_pkg::DIST_W) + 1;
    localparam int DS_W   = $clog2(IW + 1);
    localparam int PR_W   = 2 * pdh_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GAP, S_MUL, S_ACC, S_ROOT, S_BIN,
        S_DIV, S_NEXT, S_PAIRS, S_RD, S_WR, S_RES
    } state_t;

    state_t                       state_reg;
    pdh_pkg::item_t               item_reg;
    logic                         phase_reg;
    logic signed [COORD_BITS-1:0] held_lo_reg [3];
    logic signed [COORD_BITS-1:0] held_hi_reg [3];
    logic [pdh_pkg::CNT_W-1:0]    held_cnt_reg;
    logic signed [GW-1:0]         gap_reg [3];
    logic [1:0]                   axis_reg;
    logic [SQ_W-1:0]              prod_reg;
    logic [63:0]                  acc_reg;
    logic [63:0]                  rem_reg;
    logic [63:0]                  root_reg;
    logic [63:0]                  bit_reg;
    logic [pdh_pkg::DIST_W-1:0]   dist_reg;
    logic [pdh_pkg::DIST_W-1:0]   dmin_reg;
    logic                         v0_reg;
    logic [IW-1:0]                i0_reg;
    logic                         cur_v_reg;
    logic [DV_W-1:0]              div_rem_reg;
    logic [IW-1:0]                quo_reg;
    logic [DS_W-1:0]              dstep_reg;
    logic [IW-1:0]                addr_reg;
    logic [63:0]                  add_reg;
    logic [63:0]                  mem_q_reg;
    logic [IW-1:0]                clr_cnt_reg;
    logic [NC_W-1:0]              n_eff_reg;
    logic [NW_W-1:0]              nw_reg;
    pdh_pkg::result_t             pend_reg;
    pdh_pkg::result_t             res_reg;
    logic                         res_valid_reg;

    logic [63:0]                  hist_mem [NUM_BINS];

    // per-axis coordinates of the current transaction
    logic signed [COORD_BITS-1:0] a_c [3];
    logic signed [COORD_BITS-1:0] b_c [3];
    logic signed [GW-1:0]         gap_new [3];
    logic signed [GW:0]           gap_ext;
    logic [GW:0]                  mag_w;
    logic [GW-1:0]                mag;
    logic [ACC_W-1:0]             acc_sum;
    logic [63:0]                  acc_sat;
    logic [64:0]                  trial;
    logic                         trial_ok;
    logic [63:0]                  root_new;
    logic [63:0]                  rem_new;
    logic [pdh_pkg::CFG_W-1:0]    w_eff;
    logic [NC_W-1:0]              bins_ext;
    logic                         below;
    logic [32:0]                  diff;
    logic                         in_range;
    logic [DV_W-1:0]              div_sub;
    logic                         div_ge;
    logic [IW-1:0]                quo_new;
    logic [pdh_pkg::CNT_W-1:0]    mul_b;
    logic [PR_W-1:0]              pairs;
    logic [64:0]                  upd_sum;
    logic [63:0]                  upd_val;
    logic                         prune;
    logic                         mem_we;
    logic [IW-1:0]                mem_wa;
    logic [63:0]                  mem_wd;

    always_comb
    begin
        a_c[0] = item_reg.a_x[COORD_BITS-1:0];
        a_c[1] = item_reg.a_y[COORD_BITS-1:0];
        a_c[2] = item_reg.a_z[COORD_BITS-1:0];
        b_c[0] = item_reg.b_x[COORD_BITS-1:0];
        b_c[1] = item_reg.b_y[COORD_BITS-1:0];
        b_c[2] = item_reg.b_z[COORD_BITS-1:0];
    end

    // gap per axis: point difference, or nearest / farthest box separation
    always_comb
    begin
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        logic signed [GW-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            u = '0;
            v = '0;
            m = '0;
            if (item_reg.op == pdh_pkg::OP_PAIR)
            begin
                m = GW'(a_c[i]) - GW'(b_c[i]);
            end
            else if (!phase_reg)
            begin
                u = GW'(held_lo_reg[i]) - GW'(b_c[i]);
                v = GW'(a_c[i]) - GW'(held_hi_reg[i]);
                m = (u > v) ? u : v;
                if (m < 0)
                    m = '0;
            end
            else
            begin
                u = GW'(held_hi_reg[i]) - GW'(a_c[i]);
                v = GW'(b_c[i]) - GW'(held_lo_reg[i]);
                m = (u > v) ? u : v;
            end
            gap_new[i] = m;
        end
    end

    assign gap_ext = (GW + 1)'(gap_reg[axis_reg]);
    assign mag_w   = (gap_ext < 0) ? unsigned'(-gap_ext) : unsigned'(gap_ext);
    assign mag     = mag_w[GW-1:0];

    // saturating sum of squares
    assign acc_sum = ACC_W'(acc_reg) + ACC_W'(prod_reg);
    assign acc_sat = (|acc_sum[ACC_W-1:64]) ? '1 : acc_sum[63:0];

    // one digit of the integer square root
    assign trial    = {1'b0, root_reg} + {1'b0, bit_reg};
    assign trial_ok = ({1'b0, rem_reg} >= trial);
    assign rem_new  = trial_ok ? (rem_reg - trial[63:0]) : rem_reg;
    assign root_new = trial_ok ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    assign w_eff    = (cfg.bin_step == '0) ? pdh_pkg::CFG_W'(1) : cfg.bin_step;
    assign bins_ext = NC_W'(cfg.bins_in_use);

    // bin test on the finished distance
    assign below    = (dist_reg < pdh_pkg::DIST_W'(cfg.bin_min)) ||
                      (cfg.strict_low_edge && (dist_reg == pdh_pkg::DIST_W'(cfg.bin_min)));
    assign diff     = {1'b0, dist_reg} - 33'(cfg.bin_min);
    assign in_range = (CMP_W'(diff[31:0]) < CMP_W'(nw_reg));

    // restoring division, one quotient bit per step
    assign div_sub  = DV_W'(w_eff) << dstep_reg;
    assign div_ge   = (div_rem_reg >= div_sub);
    assign quo_new  = IW'({quo_reg, div_ge});

    assign mul_b    = item_reg.same_node ?
                      ((held_cnt_reg == '0) ? '0 : held_cnt_reg - pdh_pkg::CNT_W'(1)) :
                      item_reg.point_count;
    assign pairs    = PR_W'(held_cnt_reg) * PR_W'(mul_b);

    assign upd_sum  = {1'b0, mem_q_reg} + {1'b0, add_reg};
    assign upd_val  = upd_sum[64] ? '1 : upd_sum[63:0];

    assign prune    = (dmin_reg > pdh_pkg::DIST_W'(cfg.bin_max)) ||
                      (dist_reg < pdh_pkg::DIST_W'(cfg.bin_min));

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
        end
        else if (state_reg == S_WR)
        begin
            mem_we = 1'b1;
            mem_wd = (item_reg.op == pdh_pkg::OP_READ) ? '0 : upd_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_wa] <= mem_wd;
        if (state_reg == S_RD)
            mem_q_reg <= hist_mem[addr_reg];
    end

    assign take           = (state_reg == S_IDLE) && item_valid;
    assign stat.clearing  = (state_reg == S_CLEAR);
    assign stat.res_valid = res_valid_reg;
    assign res            = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            item_reg      <= '0;
            phase_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                held_lo_reg[i] <= '0;
                held_hi_reg[i] <= '0;
                gap_reg[i]     <= '0;
            end
            held_cnt_reg  <= '0;
            axis_reg      <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            dist_reg      <= '0;
            dmin_reg      <= '0;
            v0_reg        <= 1'b0;
            i0_reg        <= '0;
            cur_v_reg     <= 1'b0;
            div_rem_reg   <= '0;
            quo_reg       <= '0;
            dstep_reg     <= '0;
            addr_reg      <= '0;
            add_reg       <= '0;
            clr_cnt_reg   <= '0;
            n_eff_reg     <= '0;
            nw_reg        <= '0;
            pend_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            n_eff_reg <= (bins_ext > NC_W'(NUM_BINS)) ? NC_W'(NUM_BINS) : bins_ext;
            nw_reg    <= NW_W'(n_eff_reg) * NW_W'(w_eff);

            // result register: loaded from the result step, emptied by pop
            if ((state_reg == S_RES) && (!res_valid_reg || pop))
                res_valid_reg <= 1'b1;
            else if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + IW'(1);
                    if (clr_cnt_reg == IW'(NUM_BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg  <= item;
                        phase_reg <= 1'b0;
                        pend_reg  <= '0;
                        case (item.op)
                            pdh_pkg::OP_HOLD:
                            begin
                                held_lo_reg[0] <= item.a_x[COORD_BITS-1:0];
                                held_lo_reg[1] <= item.a_y[COORD_BITS-1:0];
                                held_lo_reg[2] <= item.a_z[COORD_BITS-1:0];
                                held_hi_reg[0] <= item.b_x[COORD_BITS-1:0];
                                held_hi_reg[1] <= item.b_y[COORD_BITS-1:0];
                                held_hi_reg[2] <= item.b_z[COORD_BITS-1:0];
                                held_cnt_reg   <= item.point_count;
                            end
                            pdh_pkg::OP_READ:
                            begin
                                addr_reg <= IW'(item.bin_select);
                                if (32'(item.bin_select) < 32'(NUM_BINS))
                                    state_reg <= S_RD;
                                else
                                    state_reg <= S_RES;
                            end
                            default:
                                state_reg <= S_GAP;
                        endcase
                    end
                end
                S_GAP:
                begin
                    for (int i = 0; i < 3; i++)
                        gap_reg[i] <= gap_new[i];
                    axis_reg  <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= SQ_W'(mag) * SQ_W'(mag);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_sat;
                    if (axis_reg == 2'd2)
                    begin
                        rem_reg   <= acc_sat;
                        root_reg  <= '0;
                        bit_reg   <= 64'h4000_0000_0000_0000;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_ROOT:
                begin
                    rem_reg  <= rem_new;
                    root_reg <= root_new;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg == 64'd1)
                    begin
                        dist_reg  <= root_new[pdh_pkg::DIST_W-1:0];
                        state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    cur_v_reg   <= !below && in_range;
                    div_rem_reg <= DV_W'(diff[31:0]);
                    quo_reg     <= '0;
                    dstep_reg   <= DS_W'(IW - 1);
                    if (!below && in_range)
                        state_reg <= S_DIV;
                    else if (item_reg.op == pdh_pkg::OP_PAIR)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_NEXT;
                end
                S_DIV:
                begin
                    if (div_ge)
                        div_rem_reg <= div_rem_reg - div_sub;
                    quo_reg   <= quo_new;
                    dstep_reg <= dstep_reg - DS_W'(1);
                    if (dstep_reg == '0)
                    begin
                        if (item_reg.op == pdh_pkg::OP_PAIR)
                        begin
                            addr_reg  <= quo_new;
                            add_reg   <= 64'd1;
                            state_reg <= S_RD;
                        end
                        else
                            state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (!phase_reg)
                    begin
                        dmin_reg  <= dist_reg;
                        v0_reg    <= cur_v_reg;
                        i0_reg    <= quo_reg;
                        phase_reg <= 1'b1;
                        state_reg <= S_GAP;
                    end
                    else if (prune)
                    begin
                        pend_reg.outcome <= pdh_pkg::OUT_PRUNED;
                        state_reg        <= S_RES;
                    end
                    else if (v0_reg && cur_v_reg && (i0_reg == quo_reg))
                    begin
                        addr_reg  <= i0_reg;
                        state_reg <= S_PAIRS;
                    end
                    else
                    begin
                        pend_reg.outcome <= pdh_pkg::OUT_SPLIT;
                        state_reg        <= S_RES;
                    end
                end
                S_PAIRS:
                begin
                    add_reg   <= item_reg.same_node ? 64'(pairs >> 1) : 64'(pairs);
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_WR;
                S_WR:
                begin
                    case (item_reg.op)
                        pdh_pkg::OP_READ:
                        begin
                            pend_reg.bin_value <= mem_q_reg;
                            state_reg          <= S_RES;
                        end
                        pdh_pkg::OP_TEST:
                        begin
                            pend_reg.outcome  <= pdh_pkg::OUT_BULK;
                            pend_reg.bulk_bin <= pdh_pkg::SEL_W'(addr_reg);
                            state_reg         <= S_RES;
                        end
                        default:
                            state_reg <= S_IDLE;
                    endcase
                end
                S_RES:
                begin
                    if (!res_valid_reg || pop)
                    begin
                        res_reg   <= pend_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pair_distance_histogram.sv =====
// pair_distance_histogram: top level with configuration registers, input queue and sequencer
//
//  channel   direction  handshake             contents
//  input     in         push / full           op, corners a_*/b_*, point_count, same_node, bin_select
//  result    out        pop / empty           outcome, bulk_bin, bin_value
//  config    in/out     psel/penable/pready   bin_min, bin_max, bin_step, bins_in_use, strict_low_edge
//
// after reset a clearing pass zeroes the histogram memory, one bin a cycle;
// full stays high during that pass, configuration writes are taken as usual
// a point pair runs three squares on one multiplier, a 32-step square root, a bin division
// of log2(NUM_BINS) steps, read and write; one that misses every bin skips division, read and write
// a box test runs the distance path twice;
// hold box only loads the held box, read and clear go through the memory read port
// a two-entry queue in front accepts transactions while the sequencer works, and one result
// register behind it holds a result until popped; the sequencer stalls only in its result
// step while that register still holds an unpopped result
module pair_distance_histogram
#(
    parameter int NUM_BINS   = 64,
    parameter int COORD_BITS = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input transactions
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        op,
    input  logic signed [COORD_BITS-1:0]      a_x,
    input  logic signed [COORD_BITS-1:0]      a_y,
    input  logic signed [COORD_BITS-1:0]      a_z,
    input  logic signed [COORD_BITS-1:0]      b_x,
    input  logic signed [COORD_BITS-1:0]      b_y,
    input  logic signed [COORD_BITS-1:0]      b_z,
    input  logic [pdh_pkg::CNT_W-1:0]         point_count,
    input  logic                              same_node,
    input  logic [pdh_pkg::SEL_W-1:0]         bin_select,
    // result transactions
    output logic                              empty,
    input  logic                              pop,
    output logic [pdh_pkg::OUTC_W-1:0]        outcome,
    output logic [pdh_pkg::SEL_W-1:0]         bulk_bin,
    output logic [pdh_pkg::VAL_W-1:0]         bin_value,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdh_pkg::PADDR_W-1:0]       paddr,
    input  logic [pdh_pkg::PDATA_W-1:0]       pwdata,
    output logic [pdh_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    pdh_pkg::cfg_t       cfg_reg;
    pdh_pkg::item_t      item_in;
    pdh_pkg::item_t      item_q;
    pdh_pkg::back_stat_t stat;
    pdh_pkg::result_t    res;
    logic                item_valid;
    logic                take;
    logic                cfg_wr;
    logic [2:0]          reg_idx;

    // register index from the word address
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_min         <= '0;
            cfg_reg.bin_max         <= pdh_pkg::CFG_W'(38400);
            cfg_reg.bin_step        <= pdh_pkg::CFG_W'(512);
            cfg_reg.bins_in_use     <= pdh_pkg::NBIN_W'(64);
            cfg_reg.strict_low_edge <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pdh_pkg::REG_BIN_MIN:   cfg_reg.bin_min         <= pwdata[23:0];
                pdh_pkg::REG_BIN_MAX:   cfg_reg.bin_max         <= pwdata[23:0];
                pdh_pkg::REG_BIN_STEP:  cfg_reg.bin_step        <= pwdata[23:0];
                pdh_pkg::REG_BINS_USED: cfg_reg.bins_in_use     <= pwdata[6:0];
                pdh_pkg::REG_STRICT:    cfg_reg.strict_low_edge <= pwdata[0];
                default:                ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            pdh_pkg::REG_BIN_MIN:   prdata = 32'(cfg_reg.bin_min);
            pdh_pkg::REG_BIN_MAX:   prdata = 32'(cfg_reg.bin_max);
            pdh_pkg::REG_BIN_STEP:  prdata = 32'(cfg_reg.bin_step);
            pdh_pkg::REG_BINS_USED: prdata = 32'(cfg_reg.bins_in_use);
            pdh_pkg::REG_STRICT:    prdata = 32'(cfg_reg.strict_low_edge);
            default:                prdata = '0;
        endcase
    end

    // coordinates travel sign extended to the widest supported width
    always_comb
    begin
        item_in.op          = op;
        item_in.a_x         = pdh_pkg::CW_MAX'(a_x);
        item_in.a_y         = pdh_pkg::CW_MAX'(a_y);
        item_in.a_z         = pdh_pkg::CW_MAX'(a_z);
        item_in.b_x         = pdh_pkg::CW_MAX'(b_x);
        item_in.b_y         = pdh_pkg::CW_MAX'(b_y);
        item_in.b_z         = pdh_pkg::CW_MAX'(b_z);
        item_in.point_count = point_count;
        item_in.same_node   = same_node;
        item_in.bin_select  = bin_select;
    end

    pdh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .hold       (stat.clearing),
        .item_in    (item_in),
        .full       (full),
        .item_valid (item_valid),
        .item_out   (item_q),
        .take       (take)
    );

    pdh_back
    #(
        .NUM_BINS   (NUM_BINS),
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item_q),
        .take       (take),
        .pop        (pop),
        .stat       (stat),
        .res        (res)
    );

    assign empty     = !stat.res_valid;
    assign outcome   = res.outcome;
    assign bulk_bin  = res.bulk_bin;
    assign bin_value = res.bin_value;

    // no transaction enters while the histogram is being cleared
    a_full_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> full)
        else $error("input accepted during clearing pass");

    // a read result carries no box outcome
    a_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (bin_value != '0)) |-> (outcome == pdh_pkg::OUT_PRUNED && bulk_bin == '0))
        else $error("bin value on a box test result");

    // bulk bin is reported only with a bulk count
    a_bulk_bin_tied: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (outcome != pdh_pkg::OUT_BULK)) |-> (bulk_bin == '0))
        else $error("bulk bin without bulk count");

    // a result stays put until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(bin_value) && $stable(outcome)))
        else $error("result changed before pop");

endmodule

// ===== verif/pdh_checker.sv =====
// pdh_checker: predicts and checks pair distance histogram results from the port activity
module pdh_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [1:0]                        op,
    input  logic signed [23:0]                a_x,
    input  logic signed [23:0]                a_y,
    input  logic signed [23:0]                a_z,
    input  logic signed [23:0]                b_x,
    input  logic signed [23:0]                b_y,
    input  logic signed [23:0]                b_z,
    input  logic [pdh_pkg::CNT_W-1:0]         point_count,
    input  logic                              same_node,
    input  logic [pdh_pkg::SEL_W-1:0]         bin_select,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [pdh_pkg::OUTC_W-1:0]        outcome,
    input  logic [pdh_pkg::SEL_W-1:0]         bulk_bin,
    input  logic [pdh_pkg::VAL_W-1:0]         bin_value,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdh_pkg::PADDR_W-1:0]       paddr,
    input  logic [pdh_pkg::PDATA_W-1:0]       pwdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending,
    output int                                results_seen
);

    localparam int BINS = 64;

    logic [63:0]        hist [BINS];
    longint             box_lo [3];
    longint             box_hi [3];
    logic [63:0]        box_count;
    pdh_pkg::cfg_t      cfg;
    pdh_pkg::result_t   expected_q [$];

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] separation(longint g0, longint g1, longint g2);
        longint      g [3];
        logic [63:0] s;
        logic [63:0] m;
        g = '{g0, g1, g2};
        s = 0;
        foreach (g[i])
        begin
            m = (g[i] < 0) ? 64'(-g[i]) : 64'(g[i]);
            s = sat_sum(s, m * m);
        end
        return root_floor(s);
    endfunction

    function automatic bit bin_for(logic [63:0] d, output int idx);
        logic [63:0] w;
        logic [63:0] n;
        logic [63:0] k;
        w = (cfg.bin_step == 0) ? 64'd1 : 64'(cfg.bin_step);
        n = (cfg.bins_in_use > BINS) ? 64'(BINS) : 64'(cfg.bins_in_use);
        idx = 0;
        if (d < cfg.bin_min || (cfg.strict_low_edge && d == cfg.bin_min))
            return 0;
        k = (d - cfg.bin_min) / w;
        if (k >= n)
            return 0;
        idx = int'(k);
        return 1;
    endfunction

    // works out the effect of one transaction; returns 1 when it yields a result
    function automatic bit histogram_step(output pdh_pkg::result_t r);
        longint      a [3];
        longint      b [3];
        longint      g [3];
        longint      u;
        longint      v;
        logic [63:0] dmin;
        logic [63:0] dmax;
        logic [63:0] pairs;
        int          i0;
        int          i1;
        a = '{longint'(a_x), longint'(a_y), longint'(a_z)};
        b = '{longint'(b_x), longint'(b_y), longint'(b_z)};
        r = '0;
        case (op)
            pdh_pkg::OP_PAIR:
            begin
                if (bin_for(separation(a[0] - b[0], a[1] - b[1], a[2] - b[2]), i0))
                    hist[i0] = sat_sum(hist[i0], 64'd1);
                return 0;
            end
            pdh_pkg::OP_HOLD:
            begin
                box_lo = a;
                box_hi = b;
                box_count = 64'(point_count);
                return 0;
            end
            pdh_pkg::OP_TEST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    u = box_lo[i] - b[i];
                    v = a[i] - box_hi[i];
                    g[i] = (u > v) ? u : v;
                    if (g[i] < 0)
                        g[i] = 0;
                end
                dmin = separation(g[0], g[1], g[2]);
                for (int i = 0; i < 3; i++)
                begin
                    u = box_hi[i] - a[i];
                    v = b[i] - box_lo[i];
                    g[i] = (u > v) ? u : v;
                end
                dmax = separation(g[0], g[1], g[2]);
                if (dmin > cfg.bin_max || dmax < cfg.bin_min)
                    r.outcome = pdh_pkg::OUT_PRUNED;
                else if (bin_for(dmin, i0) && bin_for(dmax, i1) && i0 == i1)
                begin
                    if (same_node)
                        pairs = (box_count != 0) ? (box_count * (box_count - 1)) / 2 : 0;
                    else
                        pairs = box_count * 64'(point_count);
                    hist[i0] = sat_sum(hist[i0], pairs);
                    r.outcome = pdh_pkg::OUT_BULK;
                    r.bulk_bin = pdh_pkg::SEL_W'(i0);
                end
                else
                    r.outcome = pdh_pkg::OUT_SPLIT;
                return 1;
            end
            default:
            begin
                r.outcome = pdh_pkg::OUT_PRUNED;
                r.bin_value = hist[bin_select];
                hist[bin_select] = 0;
                return 1;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pdh_pkg::result_t want;
        pdh_pkg::result_t got;
        if (!rst_n)
        begin
            foreach (hist[i])
                hist[i] = 0;
            box_lo = '{0, 0, 0};
            box_hi = '{0, 0, 0};
            box_count = 0;
            cfg.bin_min = 0;
            cfg.bin_max = 24'd38400;
            cfg.bin_step = 24'd512;
            cfg.bins_in_use = 7'd64;
            cfg.strict_low_edge = 0;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[pdh_pkg::PADDR_W-1:2])
                    pdh_pkg::REG_BIN_MIN:   cfg.bin_min = pwdata[pdh_pkg::CFG_W-1:0];
                    pdh_pkg::REG_BIN_MAX:   cfg.bin_max = pwdata[pdh_pkg::CFG_W-1:0];
                    pdh_pkg::REG_BIN_STEP:  cfg.bin_step = pwdata[pdh_pkg::CFG_W-1:0];
                    pdh_pkg::REG_BINS_USED: cfg.bins_in_use = pwdata[pdh_pkg::NBIN_W-1:0];
                    pdh_pkg::REG_STRICT:    cfg.strict_low_edge = pwdata[0];
                    default: ;
                endcase
            end
            // result side first: a result always belongs to an older transaction
            if (pop && !empty)
            begin
                got.outcome = outcome;
                got.bulk_bin = bulk_bin;
                got.bin_value = bin_value;
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: outcome %0d bulk_bin %0d bin_value %0d",
                                 outcome, bulk_bin, bin_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: outcome %0d/%0d bulk_bin %0d/%0d value %0d/%0d",
                                     want.outcome, got.outcome, want.bulk_bin, got.bulk_bin,
                                     want.bin_value, got.bin_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (push && !full)
            begin
                if (histogram_step(want))
                    expected_q.push_back(want);
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// testbench: stimulus, configuration phases and verdict for the pair distance histogram
module testbench;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [1:0]                    op;
    logic signed [23:0]            a_x, a_y, a_z, b_x, b_y, b_z;
    logic [pdh_pkg::CNT_W-1:0]     point_count;
    logic                          same_node;
    logic [pdh_pkg::SEL_W-1:0]     bin_select;
    logic                          empty;
    logic                          pop;
    logic [pdh_pkg::OUTC_W-1:0]    outcome;
    logic [pdh_pkg::SEL_W-1:0]     bulk_bin;
    logic [pdh_pkg::VAL_W-1:0]     bin_value;
    logic                          psel, penable, pwrite;
    logic [pdh_pkg::PADDR_W-1:0]   paddr;
    logic [pdh_pkg::PDATA_W-1:0]   pwdata;
    logic [pdh_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    int fail_count;
    int pending;
    int results_seen;

    // idle chances in percent, changed per phase by the stimulus process
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  rx_hold_req;      // asks the result side for one long hold-off
    int  items_sent;
    int  idle_run;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 300;   // a box test plus two queued point pairs

    pair_distance_histogram u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .op(op),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .point_count(point_count), .same_node(same_node), .bin_select(bin_select),
        .empty(empty), .pop(pop), .outcome(outcome), .bulk_bin(bulk_bin),
        .bin_value(bin_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pdh_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .op(op),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .point_count(point_count), .same_node(same_node), .bin_select(bin_select),
        .empty(empty), .pop(pop), .outcome(outcome), .bulk_bin(bulk_bin),
        .bin_value(bin_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: cycles in which neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_run <= 0;
        else if (idle_run + 1 >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // result side: random pop, plus one long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                rx_hold_req = 0;
                repeat (400) @(negedge clk);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one configuration write: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pdh_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bins(int lo, int hi, int width, int used, bit strict);
        reg_write(pdh_pkg::REG_BIN_MIN, 32'(lo));
        reg_write(pdh_pkg::REG_BIN_MAX, 32'(hi));
        reg_write(pdh_pkg::REG_BIN_STEP, 32'(width));
        reg_write(pdh_pkg::REG_BINS_USED, 32'(used));
        reg_write(pdh_pkg::REG_STRICT, 32'(strict));
    endtask

    // offers one transaction from a falling edge until it is taken
    task automatic offer(logic [1:0] o, int ax, int ay, int az, int bx, int by, int bz,
                         int cnt, bit same, int sel);
        bit taken;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        push <= 1'b1;
        op <= o;
        a_x <= 24'(ax); a_y <= 24'(ay); a_z <= 24'(az);
        b_x <= 24'(bx); b_y <= 24'(by); b_z <= 24'(bz);
        point_count <= pdh_pkg::CNT_W'(cnt);
        same_node <= same;
        bin_select <= pdh_pkg::SEL_W'(sel);
        do
        begin
            taken = !full;
            @(negedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic go_quiet();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // mostly short coordinates so distances land in the bins, now and then any value
    function automatic int coord();
        if ($urandom_range(99) < 8)
            return $signed(24'($urandom));
        return $urandom_range(6000) - 3000;
    endfunction

    function automatic int count_value();
        if ($urandom_range(9) == 0)
            return 24'($urandom);
        return $urandom_range(50);
    endfunction

    // box-pair walk: hold a node, at random test it against itself, then test near boxes, some malformed
    task automatic box_walk();
        int lx, ly, lz, sz, dx, dy, dz, n;
        lx = coord(); ly = coord(); lz = coord();
        sz = $urandom_range(40);
        n = count_value();
        offer(pdh_pkg::OP_HOLD, lx, ly, lz, lx + sz, ly + sz, lz + sz, n, 0, 0);
        if ($urandom_range(1))
            offer(pdh_pkg::OP_TEST, lx, ly, lz, lx + sz, ly + sz, lz + sz, n, 1, 0);
        repeat ($urandom_range(1, 3))
        begin
            dx = $urandom_range(2000) - 1000;
            dy = $urandom_range(200) - 100;
            dz = $urandom_range(200) - 100;
            if ($urandom_range(9) == 0)
                // corners swapped: a malformed box
                offer(pdh_pkg::OP_TEST, lx + dx + sz, ly + dy + sz, lz + dz + sz, lx + dx,
                      ly + dy, lz + dz, count_value(), 0, 0);
            else
                offer(pdh_pkg::OP_TEST, lx + dx, ly + dy, lz + dz, lx + dx + $urandom_range(40),
                      ly + dy + $urandom_range(40), lz + dz + $urandom_range(40),
                      count_value(), $urandom_range(1), 0);
        end
    endtask

    // sends transactions until about the given amount has gone in
    task automatic random_items(int amount);
        int start;
        int kind;
        start = items_sent;
        while (items_sent - start < amount)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                offer(pdh_pkg::OP_PAIR, coord(), coord(), coord(), coord(), coord(), coord(),
                      $urandom, $urandom, $urandom);
            else if (kind < 75)
                box_walk();
            else if (kind < 90)
                offer(pdh_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom_range(63));
            else
                // noise: any field value with any op
                offer(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // edge cases of each setting: low edge exactly, zero distance, widest gap, reads
    task automatic directed_items(int lo);
        offer(pdh_pkg::OP_PAIR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer(pdh_pkg::OP_PAIR, 0, 0, 0, lo, 0, 0, 0, 0, 0);
        offer(pdh_pkg::OP_PAIR, 0, 0, 0, lo + 1, 0, 0, 0, 0, 0);
        offer(pdh_pkg::OP_PAIR, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              0, 0, 0);
        offer(pdh_pkg::OP_HOLD, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              24'hFFFFFF, 0, 0);
        offer(pdh_pkg::OP_TEST, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              24'hFFFFFF, 0, 0);
        offer(pdh_pkg::OP_TEST, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1, 0);
        offer(pdh_pkg::OP_HOLD, 0, 0, 0, 4, 4, 4, 10, 0, 0);
        offer(pdh_pkg::OP_TEST, 0, 0, 0, 4, 4, 4, 10, 1, 0);
        offer(pdh_pkg::OP_TEST, 100, 0, 0, 104, 4, 4, 7, 0, 0);
        offer(pdh_pkg::OP_TEST, 8000000, 0, 0, 8000004, 4, 4, 3, 0, 0);
        offer(pdh_pkg::OP_TEST, 2000, 0, 0, 0, 2000, 0, 5, 0, 0);
        offer(pdh_pkg::OP_HOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer(pdh_pkg::OP_TEST, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        offer(pdh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer(pdh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 63);
        offer(pdh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    endtask

    initial
    begin
        int lo_edge [4];
        rst_n = 1'b0;
        push = 1'b0;
        op = pdh_pkg::OP_PAIR;
        {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
        point_count = '0;
        same_node = 1'b0;
        bin_select = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_hold_req = 0;
        items_sent = 0;
        idle_run = 0;
        tx_idle_pct = 32;
        rx_idle_pct = 69;
        lo_edge = '{0, 1280, 0, 256};
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            // four settings, extremes among them: plain, tight unit bins,
            // one huge bin, zero width with no bins counted
            case (ph)
                0: set_bins(0, 38400, 512, 64, 0);
                1: set_bins(1280, 24'hFFFFFF, 1, 127, 1);
                2: set_bins(0, 0, 24'hFFFFFF, 1, 0);
                default: set_bins(256, 20000, 0, 0, 1);
            endcase
            if (ph == 2)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 32;
            end
            else if (ph == 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            directed_items(lo_edge[ph]);
            if (ph == 1)
            begin
                // long receiver hold-off while reads keep coming: the queue backs up
                rx_hold_req = 1;
                repeat (12)
                    offer(pdh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(63));
            end
            random_items(50);
            // sender pause until every outstanding result has been taken
            push <= 1'b0;
            @(negedge clk);
            while (pending != 0)
                @(negedge clk);
            random_items(60);
            go_quiet();
        end

        $display("covered %0d input transactions and %0d results over four bin settings",
                 items_sent, results_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
